### design/kst_pkg.sv
package kst_pkg;

	localparam logic [1:0] REQ_EVENT   = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	localparam logic [1:0] MODE_UP    = 2'd0;
	localparam logic [1:0] MODE_DOWN  = 2'd1;
	localparam logic [1:0] MODE_STUCK = 2'd2;

	localparam logic [2:0] RK_ACCEPTED  = 3'd0;
	localparam logic [2:0] RK_INVALID   = 3'd1;
	localparam logic [2:0] RK_STALE     = 3'd2;
	localparam logic [2:0] RK_RECOVERED = 3'd3;
	localparam logic [2:0] RK_RELEASE   = 3'd4;
	localparam logic [2:0] RK_QUERY     = 3'd5;

	localparam logic [2:0] CFG_STALE_EN    = 3'd0;
	localparam logic [2:0] CFG_STALE_THR   = 3'd1;
	localparam logic [2:0] CFG_RECOVERY_EN = 3'd2;
	localparam logic [2:0] CFG_MOD_ONLY    = 3'd3;
	localparam logic [2:0] CFG_REG_TMO_EN  = 3'd4;
	localparam logic [2:0] CFG_MOD_TMO     = 3'd5;
	localparam logic [2:0] CFG_REG_TMO     = 3'd6;

	localparam logic        RST_STALE_EN    = 1'b1;
	localparam logic [15:0] RST_STALE_THR   = 16'd100;
	localparam logic        RST_RECOVERY_EN = 1'b1;
	localparam logic        RST_MOD_ONLY    = 1'b0;
	localparam logic        RST_REG_TMO_EN  = 1'b1;
	localparam logic [15:0] RST_MOD_TMO     = 16'd5000;
	localparam logic [15:0] RST_REG_TMO     = 16'd10000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  key;
		logic [1:0]  state;
		logic [15:0] trans_cnt;
		logic [15:0] inval_cnt;
		logic [15:0] recov_cnt;
	} res_t;

endpackage

### design/kst_table.sv
module kst_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	// An entry that has never been written reads as all zeros.
	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

### design/key_state_tracker_stuck_recovery.sv
// Key event or query: accepted when idle, busy in the event state, result registered from it.
// Event or query on a key beyond the table: result strobed in the next cycle, busy stays low.
// Tick and release all: one table entry per cycle, busy in scan and flush states, releases
// strobed while the scan runs and the final one in the cycle after busy falls.
// Reset restores the register defaults and marks every table entry as zero through valid bits.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module key_state_tracker_stuck_recovery #(
	parameter int NUM_KEYS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [5:0]  key_index,
	input  logic        key_is_modifier,
	input  logic        is_down,
	input  logic [31:0] time_ms,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        result_valid,
	output logic [2:0]  result_kind,
	output logic [5:0]  out_key,
	output logic [1:0]  key_state,
	output logic [15:0] transition_count,
	output logic [15:0] invalid_count,
	output logic [15:0] recovery_count,
	output logic        last
);

	import kst_pkg::*;

	localparam int AW = $clog2(NUM_KEYS);
	localparam int CB = COUNT_BITS;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_KEYS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVT   = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0]    mode;
		logic [31:0]   seen;
		logic          modk;
		logic [CB-1:0] acc;
		logic [CB-1:0] rej;
		logic [CB-1:0] rec;
	} entry_t;

	localparam int EW = $bits(entry_t);

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [15:0] cnt16(input logic [CB-1:0] c);
		logic [31:0] t;
		t = 32'(c);
		cnt16 = t[15:0];
	endfunction

	logic          cfg_stale_en_q;
	logic [15:0]   cfg_stale_thr_q;
	logic          cfg_recovery_en_q;
	logic          cfg_mod_only_q;
	logic          cfg_reg_tmo_en_q;
	logic [15:0]   cfg_mod_tmo_q;
	logic [15:0]   cfg_reg_tmo_q;

	logic [1:0]    state_q;
	logic [1:0]    req_q;
	logic [5:0]    key_q;
	logic          mod_q;
	logic          down_q;
	logic [31:0]   now_q;
	logic [AW-1:0] idx_s1;
	logic          pend_vld_q;
	res_t          pend_q;
	res_t          res_q;
	logic          res_vld_q;
	logic          res_last_q;

	logic          accept;
	logic          in_range;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        ent;
	entry_t        nxt;
	logic [31:0]   diff;
	logic [32:0]   stale_sum;
	logic [32:0]   tmo_sum;
	logic          held;
	logic          ismod;
	logic          hit;
	logic [2:0]    kind;
	res_t          r_new;
	logic          emit_en;
	logic          emit_last;
	res_t          emit_res;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign in_range = {1'b0, key_index} < 7'(NUM_KEYS);

	kst_table #(
		.DEPTH(NUM_KEYS),
		.WIDTH(EW)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (nxt)
	);

	assign ent = rd_data;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (accept) begin
			if (req_type == REQ_EVENT || req_type == REQ_QUERY) begin
				rd_en   = in_range;
				rd_addr = key_index[AW-1:0];
			end else begin
				rd_en = 1'b1;
			end
		end else if (state_q == ST_SCAN && idx_s1 != LAST_IDX) begin
			rd_en   = 1'b1;
			rd_addr = idx_s1 + 1'b1;
		end
	end

	assign diff      = now_q - ent.seen;
	assign stale_sum = {diff[31], diff} + {17'b0, cfg_stale_thr_q};
	assign ismod     = ent.modk;
	assign tmo_sum   = {17'b0, ismod ? cfg_mod_tmo_q : cfg_reg_tmo_q} - {diff[31], diff};
	assign held      = (ent.mode == MODE_DOWN) || (ent.mode == MODE_STUCK);

	always_comb begin
		nxt     = ent;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		hit     = 1'b0;
		kind    = RK_RELEASE;
		if (state_q == ST_EVT) begin
			wr_addr = key_q[AW-1:0];
			if (req_q == REQ_QUERY) begin
				kind = RK_QUERY;
			end else begin
				wr_en    = 1'b1;
				nxt.modk = mod_q;
				priority if (cfg_stale_en_q && stale_sum[32]) begin
					kind = RK_STALE;
				end else if ((ent.mode == MODE_UP && down_q) || (held && !down_q)) begin
					nxt.mode = down_q ? MODE_DOWN : MODE_UP;
					nxt.seen = now_q;
					nxt.acc  = sat_inc(ent.acc);
					if (!down_q && ent.mode == MODE_STUCK) begin
						nxt.rec = sat_inc(ent.rec);
						kind    = RK_RECOVERED;
					end else begin
						kind = RK_ACCEPTED;
					end
				end else begin
					nxt.rej = sat_inc(ent.rej);
					kind    = RK_INVALID;
				end
			end
		end else if (state_q == ST_SCAN) begin
			wr_en = 1'b1;
			if (req_q == REQ_TICK) begin
				hit = held && cfg_recovery_en_q && !(cfg_mod_only_q && !ismod) &&
					(ismod || cfg_reg_tmo_en_q) && tmo_sum[32];
				if (hit) begin
					nxt.mode = MODE_STUCK;
					nxt.rec  = sat_inc(ent.rec);
				end
			end else begin
				hit      = held;
				nxt.mode = MODE_UP;
				nxt.seen = now_q;
			end
		end
	end

	always_comb begin
		r_new.kind      = kind;
		r_new.key       = (state_q == ST_SCAN) ? 6'(idx_s1) : key_q;
		r_new.state     = nxt.mode;
		r_new.trans_cnt = cnt16(nxt.acc);
		r_new.inval_cnt = cnt16(nxt.rej);
		r_new.recov_cnt = cnt16(nxt.rec);
	end

	always_comb begin
		emit_en   = 1'b0;
		emit_last = 1'b1;
		emit_res  = r_new;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !in_range &&
					(req_type == REQ_EVENT || req_type == REQ_QUERY)) begin
					emit_en       = 1'b1;
					emit_res      = '0;
					emit_res.kind = (req_type == REQ_EVENT) ? RK_INVALID : RK_QUERY;
					emit_res.key  = key_index;
				end
			end
			ST_EVT: begin
				emit_en = 1'b1;
			end
			ST_SCAN: begin
				emit_en   = hit && pend_vld_q;
				emit_last = 1'b0;
				emit_res  = pend_q;
			end
			ST_FLUSH: begin
				emit_en  = pend_vld_q;
				emit_res = pend_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
			idx_s1     <= '0;
		end else begin
			res_vld_q <= emit_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_EVENT || req_type == REQ_QUERY) begin
							state_q <= in_range ? ST_EVT : ST_IDLE;
						end else begin
							state_q    <= ST_SCAN;
							idx_s1     <= '0;
							pend_vld_q <= 1'b0;
						end
					end
				end
				ST_EVT: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (hit) begin
						pend_vld_q <= 1'b1;
					end
					if (idx_s1 == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_s1 <= idx_s1 + 1'b1;
					end
				end
				ST_FLUSH: begin
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			key_q  <= key_index;
			mod_q  <= key_is_modifier;
			down_q <= is_down;
			now_q  <= time_ms;
		end
		if (state_q == ST_SCAN && hit) begin
			pend_q <= r_new;
		end
		if (emit_en) begin
			res_q      <= emit_res;
			res_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_stale_en_q    <= RST_STALE_EN;
			cfg_stale_thr_q   <= RST_STALE_THR;
			cfg_recovery_en_q <= RST_RECOVERY_EN;
			cfg_mod_only_q    <= RST_MOD_ONLY;
			cfg_reg_tmo_en_q  <= RST_REG_TMO_EN;
			cfg_mod_tmo_q     <= RST_MOD_TMO;
			cfg_reg_tmo_q     <= RST_REG_TMO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STALE_EN:    cfg_stale_en_q    <= cfg_wdata[0];
				CFG_STALE_THR:   cfg_stale_thr_q   <= cfg_wdata;
				CFG_RECOVERY_EN: cfg_recovery_en_q <= cfg_wdata[0];
				CFG_MOD_ONLY:    cfg_mod_only_q    <= cfg_wdata[0];
				CFG_REG_TMO_EN:  cfg_reg_tmo_en_q  <= cfg_wdata[0];
				CFG_MOD_TMO:     cfg_mod_tmo_q     <= cfg_wdata;
				CFG_REG_TMO:     cfg_reg_tmo_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign result_valid     = res_vld_q;
	assign result_kind      = res_q.kind;
	assign out_key          = res_q.key;
	assign key_state        = res_q.state;
	assign transition_count = res_q.trans_cnt;
	assign invalid_count    = res_q.inval_cnt;
	assign recovery_count   = res_q.recov_cnt;
	assign last             = res_last_q;

`ifndef ASSERT_OFF
	a_evt_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVT) |=> (result_valid && last))
		else $error("event or query gave no final result");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("pending release outside a scan");

	a_scan_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && state_q == ST_SCAN) |-> !last)
		else $error("final mark during a running scan");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("table read and write hit the same entry");
`endif

endmodule
